FILE: design/sorted_priority_queue_defines.svh
// ---------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared clocked assertion forms for the queue RTL.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define SPQ_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue cells and top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;
  localparam int PRIO_W = 16;
  localparam int CAP_W  = 5;
  localparam int OCC_W  = 5;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

FILE: design/sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a row of shifting cells.
// ---------------------------------------------------------------------------
// Takes one operation every clock cycle (busy is always low) and shows its
// result on the out_ ports for one cycle, flagged by out_valid, on the cycle
// after start. The row of cells updates in the same edge that accepts the
// item, so each operation sees the one before it. The result cannot be held
// off: a receiver must take out_* whenever out_valid is high.
`timescale 1ns / 1ps
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue import spq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_op,
  input  logic signed [DATA_W-1:0] in_data,
  input  logic signed [PRIO_W-1:0] in_priority,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_data,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_data,
  output logic signed [PRIO_W-1:0] out_priority,
  output logic [OCC_W-1:0]         out_occupancy
);

  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic                     valid_r;
  status_t                  status_r, status_nxt;
  logic signed [DATA_W-1:0] odata_r, odata_nxt;
  logic signed [PRIO_W-1:0] oprio_r, oprio_nxt;

  logic                     accept;
  op_t                      op;
  logic                     full;
  logic                     empty;
  cell_ctrl_t               ctrl;
  logic [IDX_W-1:0]         top_idx;

  logic [DEPTH-1:0]                occ;
  logic [DEPTH-1:0]                ins;
  logic signed [DATA_W-1:0]        cell_data [DEPTH];
  logic signed [PRIO_W-1:0]        cell_prio [DEPTH];
  logic [DEPTH-1:0]                order_ok;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = op_t'(in_op);
  assign empty  = (count_r == '0);
  // full once count reaches the smaller of capacity and the row length
  assign full   = (CMP_W'(count_r) >= CMP_W'(capacity_r)) || (count_r == CNT_W'(DEPTH));
  assign top_idx = IDX_W'(count_r - CNT_W'(1));

  assign ctrl.enq = accept && (op == OP_ENQ) && !full;
  assign ctrl.deq = accept && (op == OP_DEQ) && !empty;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    assign occ[k] = (CMP_W'(count_r) > CMP_W'(k));

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (occ[k]),
      .new_data  (in_data),
      .new_prio  (in_priority),
      .prev_ins  ((k == 0) ? 1'b0 : ins[(k == 0) ? 0 : k - 1]),
      .prev_data (cell_data[(k == 0) ? 0 : k - 1]),
      .prev_prio (cell_prio[(k == 0) ? 0 : k - 1]),
      .next_data (cell_data[(k == DEPTH - 1) ? k : k + 1]),
      .next_prio (cell_prio[(k == DEPTH - 1) ? k : k + 1]),
      .ins       (ins[k]),
      .data      (cell_data[k]),
      .prio      (cell_prio[k])
    );

    if (k == 0) begin : g_first
      assign order_ok[k] = 1'b1;
    end else begin : g_rest
      assign order_ok[k] = !occ[k] || (cell_prio[k-1] <= cell_prio[k]);
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    odata_nxt  = '0;
    oprio_nxt  = '0;
    case (op)
      OP_ENQ: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          odata_nxt = cell_data[0];
          oprio_nxt = cell_prio[0];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          odata_nxt = cell_data[top_idx];
          oprio_nxt = cell_prio[top_idx];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      count_r    <= '0;
      valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_data;
      end
      valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result payload: load on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      odata_r  <= odata_nxt;
      oprio_r  <= oprio_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_data      = odata_r;
  assign out_priority  = oprio_r;
  assign out_occupancy = OCC_W'(count_r);

  `SPQ_ASSERT_ALWAYS(a_count_bound, !rst_n || (count_r <= CNT_W'(DEPTH)), "count above depth")
  `SPQ_ASSERT_CLK(a_result_next, start |=> out_valid, "no result after start")
  `SPQ_ASSERT_CLK(a_full_hold, (out_valid && out_status == ST_FULL) |-> (count_r == $past(count_r)), "full changed count")
  `SPQ_ASSERT_CLK(a_empty_zero, (out_valid && out_status == ST_EMPTY) |-> (count_r == '0), "empty with entries")
  `SPQ_ASSERT_CLK(a_sorted, &order_ok, "row out of order")

endmodule

FILE: design/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry and shifts with its neighbors.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic                     occupied,
  input  logic signed [DATA_W-1:0] new_data,
  input  logic signed [PRIO_W-1:0] new_prio,
  input  logic                     prev_ins,
  input  logic signed [DATA_W-1:0] prev_data,
  input  logic signed [PRIO_W-1:0] prev_prio,
  input  logic signed [DATA_W-1:0] next_data,
  input  logic signed [PRIO_W-1:0] next_prio,
  output logic                     ins,
  output logic signed [DATA_W-1:0] data,
  output logic signed [PRIO_W-1:0] prio
);

  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic signed [PRIO_W-1:0] prio_r, prio_nxt;

  // at or after the insert point: free slot, or strictly greater priority
  assign ins = !occupied || (prio_r > new_prio);

  always_comb begin
    data_nxt = data_r;
    prio_nxt = prio_r;
    if (ctrl.enq && ins) begin
      if (prev_ins) begin
        data_nxt = prev_data;
        prio_nxt = prev_prio;
      end else begin
        data_nxt = new_data;
        prio_nxt = new_prio;
      end
    end else if (ctrl.deq) begin
      data_nxt = next_data;
      prio_nxt = next_prio;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign data = data_r;
  assign prio = prio_r;

endmodule

FILE: tb/sv/sorted_priority_queue_tb.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue_tb
// Drives enqueue, dequeue, peek and unused operations into the queue under
// several capacity settings and sender idle rates. Each result is compared
// field by field with a typed expectation or the shadow sorted list's result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
  import spq_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   data;
    logic [PRIO_W-1:0]   prio;
    logic [OCC_W-1:0]    occ;
  } result_t;

  typedef struct packed {
    bit                  wr_cap;
    logic [CAP_W-1:0]    cap;
    op_t                 op;
    logic [DATA_W-1:0]   data;
    logic [PRIO_W-1:0]   prio;
    bit                  typed;
    result_t             want;
  } step_row_t;

  typedef struct packed {
    logic [CAP_W-1:0]    cap;
    logic [7:0]          idle_pct;
    logic [7:0]          enq_pct;
    logic [7:0]          deq_pct;
    logic [1:0]          prio_mode;
    logic [15:0]         items;
  } phase_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_op;
  logic signed [DATA_W-1:0] in_data;
  logic signed [PRIO_W-1:0] in_priority;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_data;
  logic out_valid;
  logic [1:0] out_status;
  logic signed [DATA_W-1:0] out_data;
  logic signed [PRIO_W-1:0] out_priority;
  logic [OCC_W-1:0] out_occupancy;

  // Typed expectation travels with the item it belongs to
  logic    stim_typed;
  result_t stim_want;

  result_t pending_results[$];
  int      error_count = 0;

  // Shadow of the sorted list, slot 0 holds the lowest priority
  logic [DATA_W-1:0]        shadow_data [DEPTH];
  logic signed [PRIO_W-1:0] shadow_prio [DEPTH];
  int                       shadow_count = 0;
  logic [CAP_W-1:0]         shadow_cap = CAP_RESET;

  localparam step_row_t DIRECTED_STEPS [24] = '{
    '{1'b0, 5'd0,  OP_DEQ,  32'h0000_0000, 16'h0000, 1'b1,
      '{ST_EMPTY, 32'h0000_0000, 16'h0000, 5'd0}},
    '{1'b0, 5'd0,  OP_PEEK, 32'h0000_0000, 16'h0000, 1'b1,
      '{ST_EMPTY, 32'h0000_0000, 16'h0000, 5'd0}},
    '{1'b0, 5'd0,  OP_NOP,  32'hffff_ffff, 16'hffff, 1'b1,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd0}},
    '{1'b0, 5'd0,  OP_ENQ,  32'h7fff_ffff, 16'h7fff, 1'b1,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd1}},
    '{1'b0, 5'd0,  OP_ENQ,  32'h8000_0000, 16'h8000, 1'b1,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd2}},
    '{1'b0, 5'd0,  OP_ENQ,  32'hffff_ffff, 16'h0000, 1'b1,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd3}},
    '{1'b0, 5'd0,  OP_ENQ,  32'h0000_0000, 16'h0000, 1'b1,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd4}},
    '{1'b0, 5'd0,  OP_ENQ,  32'h0000_0005, 16'h7fff, 1'b1,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd5}},
    // newest among equal highest priorities
    '{1'b0, 5'd0,  OP_PEEK, 32'h0000_0000, 16'h0000, 1'b1,
      '{ST_OK,    32'h0000_0005, 16'h7fff, 5'd5}},
    '{1'b0, 5'd0,  OP_DEQ,  32'h0000_0000, 16'h0000, 1'b1,
      '{ST_OK,    32'h8000_0000, 16'h8000, 5'd4}},
    // oldest among equal lowest priorities
    '{1'b0, 5'd0,  OP_DEQ,  32'h0000_0000, 16'h0000, 1'b1,
      '{ST_OK,    32'hffff_ffff, 16'h0000, 5'd3}},
    '{1'b0, 5'd0,  OP_NOP,  32'ha5a5_a5a5, 16'h5a5a, 1'b0,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd0}},
    // capacity lowered below the occupancy
    '{1'b1, 5'd2,  OP_NOP,  32'h0000_0000, 16'h0000, 1'b0,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd0}},
    '{1'b0, 5'd0,  OP_ENQ,  32'h0000_0001, 16'h0001, 1'b1,
      '{ST_FULL,  32'h0000_0000, 16'h0000, 5'd3}},
    '{1'b0, 5'd0,  OP_DEQ,  32'h0000_0000, 16'h0000, 1'b1,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd2}},
    '{1'b0, 5'd0,  OP_ENQ,  32'h0000_0002, 16'h8000, 1'b1,
      '{ST_FULL,  32'h0000_0000, 16'h0000, 5'd2}},
    '{1'b0, 5'd0,  OP_DEQ,  32'h0000_0000, 16'h0000, 1'b0,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd0}},
    // zero capacity
    '{1'b1, 5'd0,  OP_NOP,  32'h0000_0000, 16'h0000, 1'b0,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd0}},
    '{1'b0, 5'd0,  OP_ENQ,  32'h0000_0003, 16'h0003, 1'b1,
      '{ST_FULL,  32'h0000_0000, 16'h0000, 5'd1}},
    '{1'b0, 5'd0,  OP_PEEK, 32'h0000_0000, 16'h0000, 1'b0,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd0}},
    '{1'b0, 5'd0,  OP_DEQ,  32'h0000_0000, 16'h0000, 1'b0,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd0}},
    '{1'b0, 5'd0,  OP_DEQ,  32'h0000_0000, 16'h0000, 1'b1,
      '{ST_EMPTY, 32'h0000_0000, 16'h0000, 5'd0}},
    // capacity above the depth
    '{1'b1, 5'd31, OP_NOP,  32'h0000_0000, 16'h0000, 1'b0,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd0}},
    '{1'b0, 5'd0,  OP_ENQ,  32'h1234_5678, 16'h8001, 1'b0,
      '{ST_OK,    32'h0000_0000, 16'h0000, 5'd0}}
  };

  // cap, idle %, enqueue %, dequeue %, priority mode, items
  localparam phase_t RANDOM_PHASES [8] = '{
    '{5'd16, 8'd0,  8'd60, 8'd30, 2'd1, 16'd120},
    '{5'd31, 8'd51, 8'd70, 8'd20, 2'd0, 16'd120},
    '{5'd5,  8'd11, 8'd50, 8'd35, 2'd2, 16'd120},
    '{5'd0,  8'd0,  8'd50, 8'd30, 2'd0, 16'd60},
    '{5'd1,  8'd51, 8'd50, 8'd35, 2'd1, 16'd100},
    '{5'd16, 8'd11, 8'd75, 8'd15, 2'd1, 16'd150},
    '{5'd12, 8'd0,  8'd35, 8'd55, 2'd0, 16'd130},
    '{5'd16, 8'd51, 8'd55, 8'd35, 2'd2, 16'd150}
  };

  sorted_priority_queue dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_data       (in_data),
    .in_priority   (in_priority),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_data      (out_data),
    .out_priority  (out_priority),
    .out_occupancy (out_occupancy)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow list and return what it yields
  function automatic result_t predict_queue_op(input op_t op,
                                               input logic [DATA_W-1:0] data,
                                               input logic signed [PRIO_W-1:0] prio);
    result_t res;
    int      limit;
    int      pos;
    res   = '{ST_OK, '0, '0, '0};
    limit = (shadow_cap < DEPTH) ? int'(shadow_cap) : DEPTH;
    case (op)
      OP_ENQ: begin
        if (shadow_count >= limit) begin
          res.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] <= prio) pos++;
          for (int k = shadow_count; k > pos; k--) begin
            shadow_data[k] = shadow_data[k-1];
            shadow_prio[k] = shadow_prio[k-1];
          end
          shadow_data[pos] = data;
          shadow_prio[pos] = prio;
          shadow_count++;
        end
      end
      OP_DEQ: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = shadow_data[0];
          res.prio = shadow_prio[0];
          for (int k = 1; k < shadow_count; k++) begin
            shadow_data[k-1] = shadow_data[k];
            shadow_prio[k-1] = shadow_prio[k];
          end
          shadow_count--;
        end
      end
      OP_PEEK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = shadow_data[shadow_count-1];
          res.prio = shadow_prio[shadow_count-1];
        end
      end
      default: ;
    endcase
    res.occ = OCC_W'(shadow_count);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 50) begin
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, field, got, want);
    end
    error_count++;
  endtask

  // Pop before push so that an item accepted on a result edge queues behind it
  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_status), 32'hffff_ffff);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_data !== want.data)
            report_mismatch("data", 32'(out_data), 32'(want.data));
          if (out_priority !== want.prio)
            report_mismatch("priority", 32'(out_priority), 32'(want.prio));
          if (out_occupancy !== want.occ)
            report_mismatch("occupancy", 32'(out_occupancy), 32'(want.occ));
        end
      end
      if (cfg_we) shadow_cap = cfg_data;
      if (start && !busy) begin
        want = predict_queue_op(op_t'(in_op), in_data, in_priority);
        pending_results.push_back(stim_typed ? stim_want : want);
      end
    end
  end

  // Return at the rising edge that accepts the item, start still high
  task automatic send_item(input op_t op, input logic [DATA_W-1:0] data,
                           input logic [PRIO_W-1:0] prio, input logic typed,
                           input result_t want);
    in_op       <= op;
    in_data     <= data;
    in_priority <= prio;
    stim_typed  <= typed;
    stim_want   <= want;
    start       <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    start <= 1'b0;
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    phase_t            ph;
    op_t               op;
    logic [PRIO_W-1:0] prio;
    int                roll;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_op       <= OP_NOP;
    in_data     <= '0;
    in_priority <= '0;
    cfg_we      <= 1'b0;
    cfg_data    <= '0;
    stim_typed  <= 1'b0;
    stim_want   <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_STEPS[i]) begin
      if (DIRECTED_STEPS[i].wr_cap) begin
        write_capacity(DIRECTED_STEPS[i].cap);
      end else begin
        send_item(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].data, DIRECTED_STEPS[i].prio,
                  DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
      end
    end

    foreach (RANDOM_PHASES[p]) begin
      ph = RANDOM_PHASES[p];
      write_capacity(ph.cap);
      for (int n = 0; n < int'(ph.items); n++) begin
        roll = $urandom_range(0, 99);
        if (roll < int'(ph.enq_pct)) op = OP_ENQ;
        else if (roll < int'(ph.enq_pct + ph.deq_pct)) op = OP_DEQ;
        else if (roll >= 97) op = OP_NOP;
        else op = OP_PEEK;
        // mode 1 crowds priorities for ties, mode 2 sits at the extremes
        case (ph.prio_mode)
          2'd1:    prio = PRIO_W'($urandom_range(0, 6)) - PRIO_W'(3);
          2'd2:    prio = ($urandom_range(0, 1) ? 16'h8000 : 16'h7fff)
                          ^ PRIO_W'($urandom_range(0, 1));
          default: prio = PRIO_W'($urandom);
        endcase
        if ($urandom_range(0, 99) < int'(ph.idle_pct)) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        send_item(op, DATA_W'($urandom), prio, 1'b0, '0);
      end
    end

    start <= 1'b0;
    drain_results();
    // catch any stray strobes after the last result
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sorted_priority_queue.f
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
tb/sv/sorted_priority_queue_tb.sv
